// ===== rtl/frame_rotator_quarter_turns_macros.svh =====
// assertion macros for the quarter-turn frame rotator
// used by the top level; expects clk and rst_n in scope
`ifndef FRAME_ROTATOR_QUARTER_TURNS_MACROS_SVH
`define FRAME_ROTATOR_QUARTER_TURNS_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define FRQT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FRQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FRQT_ASSERT_NOW(lbl, ante, cons, msg)
`define FRQT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/frqt_pkg.sv =====
// shared types and constants for the quarter-turn frame rotator
// no dependencies
`default_nettype none

package frqt_pkg;

  localparam int MAX_SIDE_DEF = 2048;
  localparam int PIX_W        = 24;
  localparam int POS_W        = 11;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_LEFT = 2'd1;
  localparam logic [1:0] ROT_HALF = 2'd2;
  localparam logic [1:0] ROT_RIGHT = 2'd3;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic capture;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/frqt_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module frqt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/frqt_ctrl.sv =====
// controller: sequences load beats, store reads and output capture
// depends on frqt_pkg
`default_nettype none

module frqt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_stall,
  input  wire frqt_pkg::ctl_sts_t sts,
  output frqt_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   in_take;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.capture = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_action == frqt_pkg::ACT_EMIT) begin
            cmd.emit  = 1'b1;
            state_nxt = S_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_READ: begin
        // read data waits in the ram until the output register frees up
        if (sts.out_free) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frqt_datapath.sv =====
// datapath: config registers, load and emit counters, address rotation,
// frame store and output register; depends on frqt_pkg and frqt_ram
`default_nettype none

module frqt_datapath #(
  parameter int MAX_SIDE = frqt_pkg::MAX_SIDE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [frqt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [frqt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [frqt_pkg::PIX_W-1:0]        pixel_in,
  input  wire frqt_pkg::ctl_cmd_t                cmd,
  output frqt_pkg::ctl_sts_t                     sts,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output frqt_pkg::out_item_t                    out_data
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int LW = CW + 1;
  localparam int EW = (LW > frqt_pkg::CFG_DATA_W) ? LW : frqt_pkg::CFG_DATA_W;
  localparam int AW = 2 * CW;
  localparam int PW = frqt_pkg::POS_W;

  // clamp a programmed side to 1..MAX_SIDE
  function automatic logic [LW-1:0] side_limit(input logic [frqt_pkg::CFG_DATA_W-1:0] v);
    logic [EW-1:0] vx;
    logic [EW-1:0] res;
    vx = EW'(v);
    if (vx == '0) begin
      res = EW'(1);
    end else if (vx > EW'(MAX_SIDE)) begin
      res = EW'(MAX_SIDE);
    end else begin
      res = vx;
    end
    return res[LW-1:0];
  endfunction

  logic [LW-1:0] w_lim_r, h_lim_r;
  logic [1:0]    rot_r;

  logic [CW-1:0] load_row_r, load_col_r, load_row_nxt, load_col_nxt;
  logic [CW-1:0] emit_row_r, emit_col_nxt, emit_col_r, emit_row_nxt;
  logic [LW-1:0] lcol_inc, lrow_inc;

  logic [LW-1:0] ow, oh;
  logic          restart;
  logic [CW-1:0] r, c, sr, sc;
  logic [LW-1:0] w_m1_r, w_m1_c, h_m1_r, h_m1_c;
  logic          last;
  logic [LW-1:0] ecol_inc, erow_inc;

  logic [PW-1:0] pend_row_r, pend_col_r;
  logic          pend_last_r;
  logic [CW+PW-1:0] row_ext, col_ext;

  logic [frqt_pkg::PIX_W-1:0] rd_pix;
  logic                       out_valid_r;
  frqt_pkg::out_item_t        out_data_r;
  logic                       out_taken;

  // configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_lim_r <= LW'(1);
      h_lim_r <= LW'(1);
      rot_r   <= frqt_pkg::ROT_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        frqt_pkg::CFG_SRC_WIDTH:  w_lim_r <= side_limit(cfg_data);
        frqt_pkg::CFG_SRC_HEIGHT: h_lim_r <= side_limit(cfg_data);
        frqt_pkg::CFG_ROTATION:   rot_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // load raster counters
  always_comb begin
    lcol_inc     = {1'b0, load_col_r} + LW'(1);
    lrow_inc     = {1'b0, load_row_r} + LW'(1);
    load_col_nxt = load_col_r;
    load_row_nxt = load_row_r;
    if (cmd.load) begin
      if (lcol_inc >= w_lim_r) begin
        load_col_nxt = '0;
        load_row_nxt = (lrow_inc >= h_lim_r) ? '0 : lrow_inc[CW-1:0];
      end else begin
        load_col_nxt = lcol_inc[CW-1:0];
      end
    end
  end

  // emit position, restart check and source coordinates
  always_comb begin
    ow      = rot_r[0] ? h_lim_r : w_lim_r;
    oh      = rot_r[0] ? w_lim_r : h_lim_r;
    restart = ({1'b0, emit_row_r} >= oh) || ({1'b0, emit_col_r} >= ow);
    r       = restart ? '0 : emit_row_r;
    c       = restart ? '0 : emit_col_r;
    w_m1_r  = w_lim_r - LW'(1) - {1'b0, r};
    w_m1_c  = w_lim_r - LW'(1) - {1'b0, c};
    h_m1_r  = h_lim_r - LW'(1) - {1'b0, r};
    h_m1_c  = h_lim_r - LW'(1) - {1'b0, c};
    case (rot_r)
      frqt_pkg::ROT_LEFT: begin
        sr = c;
        sc = w_m1_r[CW-1:0];
      end
      frqt_pkg::ROT_HALF: begin
        sr = h_m1_r[CW-1:0];
        sc = w_m1_c[CW-1:0];
      end
      frqt_pkg::ROT_RIGHT: begin
        sr = h_m1_c[CW-1:0];
        sc = r;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
    last = ({1'b0, r} == oh - LW'(1)) && ({1'b0, c} == ow - LW'(1));

    ecol_inc     = {1'b0, c} + LW'(1);
    erow_inc     = {1'b0, r} + LW'(1);
    emit_col_nxt = emit_col_r;
    emit_row_nxt = emit_row_r;
    if (cmd.emit) begin
      if (ecol_inc >= ow) begin
        emit_col_nxt = '0;
        emit_row_nxt = (erow_inc >= oh) ? '0 : erow_inc[CW-1:0];
      end else begin
        emit_col_nxt = ecol_inc[CW-1:0];
        emit_row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      emit_row_r <= emit_row_nxt;
      emit_col_r <= emit_col_nxt;
    end
  end

  // position tags of the pixel being read, trimmed to the output field width
  assign row_ext = {{PW{1'b0}}, r};
  assign col_ext = {{PW{1'b0}}, c};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_row_r  <= row_ext[PW-1:0];
      pend_col_r  <= col_ext[PW-1:0];
      pend_last_r <= last;
    end
  end

  // frame store, one entry per source position
  frqt_ram #(
    .WIDTH (frqt_pkg::PIX_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr ({load_row_r, load_col_r}),
    .wdata (pixel_in),
    .re    (cmd.emit),
    .raddr ({sr, sc}),
    .rdata (rd_pix)
  );

  // output register
  assign out_taken    = out_valid_r && !out_stall;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_data_r.pixel_out  <= rd_pix;
      out_data_r.out_row    <= pend_row_r;
      out_data_r.out_col    <= pend_col_r;
      out_data_r.frame_last <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/frame_rotator_quarter_turns.sv =====
// quarter-turn frame rotator, top level
// sequence: load beats are written to the frame store when taken; an emit beat's read
// waits in the store's read register until the output register is free; throughput: one
// load beat per cycle unless in_stall; an emit stalls input until its read is captured
// reset: rst_n synchronous active low clears counters, registers (1, 1, 0) and the
// output valid flag; the frame store is not cleared
`default_nettype none

`include "frame_rotator_quarter_turns_macros.svh"

module frame_rotator_quarter_turns #(
  parameter int MAX_SIDE = frqt_pkg::MAX_SIDE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire frqt_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output frqt_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [frqt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frqt_pkg::CFG_DATA_W-1:0] cfg_data
);

  frqt_pkg::ctl_cmd_t cmd;
  frqt_pkg::ctl_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  frqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  frqt_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (in_data.pixel_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `FRQT_ASSERT_NEXT(a_emit_blocks, in_valid && !in_stall && in_data.action, in_stall, "emit beat did not start a store read")
  `FRQT_ASSERT_NOW(a_result_after_read, $rose(out_valid), $past(in_stall), "result appeared without a store read")
  `FRQT_ASSERT_NEXT(a_read_drains, in_stall && !(out_valid && out_stall), !in_stall, "pending read not moved to output")

endmodule

`default_nettype wire
